>>> rtl/isotp_pkg.sv
package isotp_pkg;

  parameter int MsgBytesDefault = 256;
  parameter int MaxFrames       = 36;

  parameter logic [7:0] HdrFirst  = 8'h10;
  parameter logic [3:0] HdrConsec = 4'h2;
  parameter logic [7:0] HdrFlow   = 8'h30;

  typedef enum logic [2:0] {
    OpLoad   = 3'd0,
    OpStart  = 3'd1,
    OpFlowRx = 3'd2,
    OpTick   = 3'd3,
    OpSendFc = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    FkSingle,
    FkFirst,
    FkConsec,
    FkFlow
  } frame_kind_e;

  typedef struct packed {
    logic        store_wr;
    logic        fc_capture;
    logic        sep_dec;
    logic        tick_reload;
    logic        start_init;
    logic        frame_init;
    frame_kind_e frame_kind;
    logic        fill;
  } cmd_t;

  typedef struct packed {
    logic pacing;
    logic sep_zero;
    logic stat_go;
    logic bs_zero;
    logic bc_lt_bs;
    logic more;
    logic short_len;
    logic slot_last;
  } stat_t;

endpackage

>>> rtl/isotp_segmented_sender.sv
// Load, flow-control beats and tick beats that send nothing leave the block idle; busy_o stays low.
// A start or sending tick fills the frame's payload slots in turn (one store read per payload
// byte), then passes the drain state before the frame is shown. Burst frames follow the same way.
// busy_o drops the cycle after the last frame; a flow-control frame appears the cycle
// after its beat. frame_valid_o lasts one cycle and the receiver cannot stall it.
// Reset clears all control state; message store contents stay undefined until loaded.
module isotp_segmented_sender #(
  parameter int MsgBytes = isotp_pkg::MsgBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] byte_index_i,
  input  logic [7:0] byte_value_i,
  input  logic [7:0] message_length_i,
  input  logic [3:0] fc_status_i,
  input  logic [7:0] fc_blocks_i,
  input  logic [7:0] separation_time_i,
  output logic       frame_valid_o,
  output logic [7:0] frame_byte0_o,
  output logic [7:0] frame_byte1_o,
  output logic [7:0] frame_byte2_o,
  output logic [7:0] frame_byte3_o,
  output logic [7:0] frame_byte4_o,
  output logic [7:0] frame_byte5_o,
  output logic [7:0] frame_byte6_o,
  output logic [7:0] frame_byte7_o,
  output logic       last_frame_o
);

  isotp_pkg::cmd_t  cmd;
  isotp_pkg::stat_t stat;

  isotp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .operation_i   (operation_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .busy_o        (busy_o),
    .frame_valid_o (frame_valid_o),
    .last_frame_o  (last_frame_o)
  );

  isotp_dp #(
    .MsgBytes (MsgBytes)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .byte_index_i      (byte_index_i),
    .byte_value_i      (byte_value_i),
    .message_length_i  (message_length_i),
    .fc_status_i       (fc_status_i),
    .fc_blocks_i       (fc_blocks_i),
    .separation_time_i (separation_time_i),
    .stat_o            (stat),
    .frame_byte0_o     (frame_byte0_o),
    .frame_byte1_o     (frame_byte1_o),
    .frame_byte2_o     (frame_byte2_o),
    .frame_byte3_o     (frame_byte3_o),
    .frame_byte4_o     (frame_byte4_o),
    .frame_byte5_o     (frame_byte5_o),
    .frame_byte6_o     (frame_byte6_o),
    .frame_byte7_o     (frame_byte7_o)
  );

endmodule

>>> rtl/isotp_ctrl.sv
module isotp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [2:0]       operation_i,
  input  isotp_pkg::stat_t stat_i,
  output isotp_pkg::cmd_t  cmd_o,
  output logic             busy_o,
  output logic             frame_valid_o,
  output logic             last_frame_o
);

  typedef enum logic [1:0] {
    StIdle,
    StFill,
    StDrain,
    StEmit
  } state_e;

  localparam logic [5:0] CntLast = 6'(isotp_pkg::MaxFrames - 1);

  state_e     state_q, state_d;
  logic       multi_q, multi_d;
  logic [5:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic       accept;

  assign accept = start_i && (state_q == StIdle);

  always_comb begin
    cmd_o      = '0;
    cmd_o.frame_kind = isotp_pkg::FkConsec;
    state_d    = state_q;
    multi_d    = multi_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          last_d = 1'b1;
          case (isotp_pkg::op_e'(operation_i))
            isotp_pkg::OpLoad: begin
              cmd_o.store_wr = 1'b1;
            end
            isotp_pkg::OpStart: begin
              cmd_o.start_init = 1'b1;
              cmd_o.frame_init = 1'b1;
              cmd_o.frame_kind = stat_i.short_len ? isotp_pkg::FkSingle : isotp_pkg::FkFirst;
              multi_d = 1'b0;
              state_d = StFill;
            end
            isotp_pkg::OpFlowRx: begin
              cmd_o.fc_capture = 1'b1;
            end
            isotp_pkg::OpTick: begin
              if (stat_i.pacing) begin
                if (!stat_i.sep_zero) begin
                  cmd_o.sep_dec = 1'b1;
                end else begin
                  cmd_o.tick_reload = 1'b1;
                  if (stat_i.stat_go && (stat_i.bs_zero || stat_i.bc_lt_bs) && stat_i.more) begin
                    cmd_o.frame_init = 1'b1;
                    cmd_o.frame_kind = isotp_pkg::FkConsec;
                    multi_d = stat_i.bs_zero;
                    cnt_d   = '0;
                    state_d = StFill;
                  end
                end
              end
            end
            isotp_pkg::OpSendFc: begin
              cmd_o.frame_init = 1'b1;
              cmd_o.frame_kind = isotp_pkg::FkFlow;
              state_d = StEmit;
            end
            default: begin
            end
          endcase
        end
      end
      StFill: begin
        cmd_o.fill = 1'b1;
        if (stat_i.slot_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        last_d  = !multi_q || !stat_i.more || (cnt_q == CntLast);
        state_d = StEmit;
      end
      StEmit: begin
        if (multi_q && stat_i.more && (cnt_q != CntLast)) begin
          cmd_o.frame_init = 1'b1;
          cmd_o.frame_kind = isotp_pkg::FkConsec;
          cnt_d   = cnt_q + 6'd1;
          state_d = StFill;
        end else begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      multi_q <= 1'b0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      multi_q <= multi_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

  assign busy_o        = (state_q != StIdle);
  assign frame_valid_o = (state_q == StEmit);
  assign last_frame_o  = last_q;

endmodule

>>> rtl/isotp_dp.sv
module isotp_dp #(
  parameter int MsgBytes = isotp_pkg::MsgBytesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  isotp_pkg::cmd_t  cmd_i,
  input  logic [7:0]       byte_index_i,
  input  logic [7:0]       byte_value_i,
  input  logic [7:0]       message_length_i,
  input  logic [3:0]       fc_status_i,
  input  logic [7:0]       fc_blocks_i,
  input  logic [7:0]       separation_time_i,
  output isotp_pkg::stat_t stat_o,
  output logic [7:0]       frame_byte0_o,
  output logic [7:0]       frame_byte1_o,
  output logic [7:0]       frame_byte2_o,
  output logic [7:0]       frame_byte3_o,
  output logic [7:0]       frame_byte4_o,
  output logic [7:0]       frame_byte5_o,
  output logic [7:0]       frame_byte6_o,
  output logic [7:0]       frame_byte7_o
);

  localparam int         AddrW  = $clog2(MsgBytes);
  localparam logic [9:0] MsgLim = 10'(MsgBytes);

  logic [7:0] mem [MsgBytes];

  logic [7:0] total_q;
  logic [8:0] ptr_q;
  logic [3:0] seq_q;
  logic [7:0] bc_q;
  logic [9:0] sep_q;
  logic       pacing_q;
  logic [3:0] pstat_q;
  logic [7:0] pbs_q;
  logic [7:0] psep_q;
  logic [2:0] slot_q;
  logic       pend_q;
  logic       pend_ok_q;
  logic [2:0] pend_slot_q;
  logic [7:0] rd_q;
  logic [7:0] frame_q [8];

  logic [8:0] wr_idx;
  logic       wr_en;
  logic       more;
  logic       rd_en;
  logic [3:0] seq_nx;
  logic [7:0] bc_nx;
  logic [9:0] sep_dec;

  assign wr_idx = {1'b0, byte_index_i};
  assign wr_en  = cmd_i.store_wr && ({1'b0, wr_idx} < MsgLim);
  assign more   = {1'b0, ptr_q} < {2'b00, total_q};
  assign rd_en  = cmd_i.fill && more && ({1'b0, ptr_q} < MsgLim);
  assign seq_nx = seq_q + 4'd1;
  assign bc_nx  = bc_q + 8'd1;

  always_comb begin
    if (psep_q > 8'd240 && psep_q < 8'd250) begin
      sep_dec = 10'(psep_q[3:0]) * 10'd100;
    end else if (!psep_q[7]) begin
      sep_dec = {3'b000, psep_q[6:0]};
    end else begin
      sep_dec = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx[AddrW-1:0]] <= byte_value_i;
    end
    if (rd_en) begin
      rd_q <= mem[ptr_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      ptr_q       <= '0;
      seq_q       <= '0;
      bc_q        <= '0;
      sep_q       <= '0;
      pacing_q    <= 1'b0;
      pstat_q     <= '0;
      pbs_q       <= '0;
      psep_q      <= '0;
      slot_q      <= '0;
      pend_q      <= 1'b0;
      pend_ok_q   <= 1'b0;
      pend_slot_q <= '0;
    end else begin
      pend_q    <= cmd_i.fill;
      pend_ok_q <= rd_en;
      if (cmd_i.fill) begin
        pend_slot_q <= slot_q;
        slot_q      <= slot_q + 3'd1;
        if (more) begin
          ptr_q <= ptr_q + 9'd1;
        end
      end
      if (cmd_i.start_init) begin
        total_q <= message_length_i;
        ptr_q   <= '0;
        seq_q   <= '0;
        bc_q    <= '0;
        sep_q   <= '0;
      end
      if (cmd_i.fc_capture) begin
        pstat_q  <= fc_status_i;
        pbs_q    <= fc_blocks_i;
        psep_q   <= separation_time_i;
        pacing_q <= 1'b1;
        bc_q     <= '0;
      end
      if (cmd_i.sep_dec) begin
        sep_q <= sep_q - 10'd1;
      end
      if (cmd_i.tick_reload) begin
        sep_q <= sep_dec;
        if (pstat_q == 4'd0 && pbs_q != 8'd0 && bc_q < pbs_q) begin
          if (bc_nx == pbs_q) begin
            pacing_q <= 1'b0;
            bc_q     <= '0;
          end else begin
            bc_q <= bc_nx;
          end
        end
      end
      if (cmd_i.frame_init) begin
        case (cmd_i.frame_kind)
          isotp_pkg::FkFirst:  slot_q <= 3'd2;
          default:             slot_q <= 3'd1;
        endcase
        if (cmd_i.frame_kind == isotp_pkg::FkConsec) begin
          seq_q <= seq_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_init) begin
      for (int i = 1; i < 8; i++) begin
        frame_q[i] <= 8'h00;
      end
      case (cmd_i.frame_kind)
        isotp_pkg::FkSingle: begin
          frame_q[0] <= message_length_i;
        end
        isotp_pkg::FkFirst: begin
          frame_q[0] <= isotp_pkg::HdrFirst;
          frame_q[1] <= message_length_i;
        end
        isotp_pkg::FkConsec: begin
          frame_q[0] <= {isotp_pkg::HdrConsec, seq_nx};
        end
        default: begin
          frame_q[0] <= isotp_pkg::HdrFlow;
        end
      endcase
    end else if (pend_q) begin
      frame_q[pend_slot_q] <= pend_ok_q ? rd_q : 8'h00;
    end
  end

  assign stat_o.pacing    = pacing_q;
  assign stat_o.sep_zero  = (sep_q == 10'd0);
  assign stat_o.stat_go   = (pstat_q == 4'd0);
  assign stat_o.bs_zero   = (pbs_q == 8'd0);
  assign stat_o.bc_lt_bs  = (bc_q < pbs_q);
  assign stat_o.more      = more;
  assign stat_o.short_len = (message_length_i <= 8'd7);
  assign stat_o.slot_last = (slot_q == 3'd7);

  assign frame_byte0_o = frame_q[0];
  assign frame_byte1_o = frame_q[1];
  assign frame_byte2_o = frame_q[2];
  assign frame_byte3_o = frame_q[3];
  assign frame_byte4_o = frame_q[4];
  assign frame_byte5_o = frame_q[5];
  assign frame_byte6_o = frame_q[6];
  assign frame_byte7_o = frame_q[7];

endmodule
